FILE: design/periodic_cubic_table_interpolator_unit_macros.svh
// Assertion macros used by the interpolator back end.
// Expects clk_i and rst_ni in the including module.
`ifndef PERIODIC_CUBIC_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define PERIODIC_CUBIC_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// Plain property check, disabled during reset.
`define PCTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define PCTI_ASSERT_IMP(lbl, ante, cons, msg) \
  `PCTI_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: design/pcti_pkg.sv
// Shared constants and types for the periodic cubic table interpolator.
// No dependencies.
package pcti_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int QDEPTH      = 2;

  localparam int HW   = 25;        // heading width
  localparam int VW   = 32;        // value width
  localparam int IW   = 6;         // entry index width
  localparam int TSW  = 7;         // table_size width
  localparam int RW   = HW + VW;   // table word
  localparam int DW   = 64;        // datapath word
  localparam int DVW  = 28;        // divisor / interval width
  localparam int XW   = 27;        // wrapped heading width
  localparam int MW   = 51;        // secant / end slope width
  localparam int PW   = 54;        // polynomial coefficient width
  localparam int SW   = 50;        // final sum width
  localparam int FRAC = 16;

  localparam int TS_MIN = 3;
  localparam logic [TSW-1:0] TS_RESET = 7'd3;

  localparam logic signed [XW-1:0] DEG360 = 27'sd23592960;
  localparam logic [DW-3:0] LIM = '1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [IW-1:0]        index;
    logic [HW-1:0]        heading;
    logic signed [VW-1:0] value;
  } pcti_item_t;

endpackage

FILE: design/pcti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/pcti_div.sv
// Signed truncating divider, two quotient bits per cycle; zero divisor gives 0.
// Depends on pcti_pkg.
module pcti_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             go_i,
  input  logic signed [pcti_pkg::DW-1:0]   a_i,
  input  logic signed [pcti_pkg::DVW-1:0]  b_i,
  output logic                             done_o,
  output logic signed [pcti_pkg::DW-1:0]   q_o
);
  import pcti_pkg::*;

  localparam int REMW = DVW - 1;
  localparam int ITER = DW / 2;
  localparam int CW   = $clog2(ITER);

  logic [DW-1:0]   dq_q;
  logic [REMW-1:0] rem_q, ub_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q, neg_q, zero_q;

  logic [DW-1:0]   ua;
  logic [DVW-1:0]  ubw;
  logic [REMW:0]   r1, r2;
  logic            ge1, ge2;
  logic [REMW-1:0] rem1, rem2;

  always_comb begin
    ua   = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
    ubw  = b_i[DVW-1] ? DVW'(-b_i) : DVW'(b_i);
    r1   = {rem_q, dq_q[DW-1]};
    ge1  = r1 >= {1'b0, ub_q};
    rem1 = ge1 ? REMW'(r1 - {1'b0, ub_q}) : r1[REMW-1:0];
    r2   = {rem1, dq_q[DW-2]};
    ge2  = r2 >= {1'b0, ub_q};
    rem2 = ge2 ? REMW'(r2 - {1'b0, ub_q}) : r2[REMW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dq_q   <= ua;
      rem_q  <= '0;
      ub_q   <= ubw[REMW-1:0];
      neg_q  <= a_i[DW-1] ^ b_i[DVW-1];
      zero_q <= (b_i == '0);
    end else if (busy_q) begin
      dq_q  <= {dq_q[DW-3:0], ge1, ge2};
      rem_q <= rem2;
    end
  end

  assign done_o = done_q;
  assign q_o    = zero_q ? '0 : (neg_q ? -$signed(dq_q) : $signed(dq_q));

endmodule

FILE: design/pcti_mul.sv
// Saturating signed multiplier, one 8-bit digit of the multiplier per cycle.
// Depends on pcti_pkg.
module pcti_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic signed [pcti_pkg::DW-1:0] a_i,
  input  logic signed [pcti_pkg::DW-1:0] b_i,
  output logic                           done_o,
  output logic signed [pcti_pkg::DW-1:0] p_o
);
  import pcti_pkg::*;

  localparam int MAGW  = DW - 2;
  localparam int DIG   = 8;
  localparam int STEPS = DW / DIG;
  localparam int CW    = $clog2(STEPS);

  logic [MAGW-1:0] ua_q, acc_q;
  logic [DW-1:0]   ub_q;
  logic            ovf_q, neg_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;

  logic [DW-1:0]       ua_w, ub_w;
  logic [MAGW+DIG-1:0] pp;
  logic [MAGW+DIG:0]   acc_n;
  logic [MAGW-1:0]     mag;

  always_comb begin
    ua_w  = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
    ub_w  = b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
    pp    = ua_q * ub_q[DW-1 -: DIG];
    acc_n = {1'b0, acc_q, {DIG{1'b0}}} + {1'b0, pp};
    mag   = ovf_q ? LIM : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      ua_q  <= ua_w[MAGW-1:0];
      ub_q  <= ub_w;
      acc_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= a_i[DW-1] ^ b_i[DW-1];
    end else if (busy_q) begin
      ub_q  <= {ub_q[DW-DIG-1:0], {DIG{1'b0}}};
      acc_q <= acc_n[MAGW-1:0];
      ovf_q <= ovf_q | (|acc_n[MAGW+DIG:MAGW]);
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});

endmodule

FILE: design/pcti_front.sv
// Front end: accepts items, drops writes beyond the table, queues the rest.
// Depends on pcti_pkg.
module pcti_front #(
  parameter int ENTRIES = pcti_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       req_type_i,
  input  logic [pcti_pkg::IW-1:0]    entry_index_i,
  input  logic [pcti_pkg::HW-1:0]    entry_heading_i,
  input  logic signed [pcti_pkg::VW-1:0] entry_value_i,
  input  logic [pcti_pkg::HW-1:0]    query_heading_i,
  output logic                       item_valid_o,
  input  logic                       item_ready_i,
  output pcti_pkg::pcti_item_t       item_o
);
  import pcti_pkg::*;

  localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  pcti_item_t      slot_q [QDEPTH];
  logic [PTRW-1:0] wptr_q, rptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            keep, push, pop;
  pcti_item_t      item_in;

  always_comb begin
    keep = (req_type_i == REQ_QUERY) || (32'(entry_index_i) < ENTRIES);
    push = start_i && !busy_o && keep;
    pop  = item_valid_o && item_ready_i;
    item_in.req_type = req_type_i;
    item_in.index    = entry_index_i;
    item_in.heading  = (req_type_i == REQ_QUERY) ? query_heading_i : entry_heading_i;
    item_in.value    = entry_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTRW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTRW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item_in;
    end
  end

  assign busy_o       = (cnt_q == CNTW'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = slot_q[rptr_q];

endmodule

FILE: design/pcti_back.sv
// Back end: table RAM, upper-bound search, neighbor fetch and Hermite evaluation.
// Depends on pcti_pkg, pcti_ram, pcti_div, pcti_mul and the assertion macros.
`include "periodic_cubic_table_interpolator_unit_macros.svh"
module pcti_back #(
  parameter int ENTRIES = pcti_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_valid_i,
  output logic                               item_ready_o,
  input  pcti_pkg::pcti_item_t               item_i,
  input  logic [$clog2(ENTRIES+1)-1:0]       used_size_i,
  output logic                               done_o,
  output logic signed [pcti_pkg::VW-1:0]     result_value_o,
  output logic                               saturated_o
);
  import pcti_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam logic signed [SW-1:0] YMAX = SW'(32'sh7FFFFFFF);
  localparam logic signed [SW-1:0] YMIN = SW'($signed(32'h80000000));

  typedef enum logic [4:0] {
    S_IDLE, S_SRD, S_SCMP, S_FETCH, S_M0, S_M1, S_M2, S_SLOPE, S_PQ,
    S_TT, S_W, S_WT, S_V, S_TS1, S_WP, S_VQ, S_SUM
  } state_e;

  state_e state_q;
  logic   run_q;
  logic [2:0] fcnt_q;
  logic [NW-1:0] n_q, first_q, len_q, i_q;
  logic [HW-1:0] x_q;
  logic signed [XW-1:0] x0_q, x1_q, x2_q, x3_q;
  logic signed [VW-1:0] y0_q, y1_q, y2_q, y3_q;
  logic signed [MW-1:0] m0_q, m1_q, m2_q, s1_q, s2_q;
  logic signed [PW-1:0] p_q, q_q;
  logic signed [DVW-1:0] t_q, h_q;
  logic signed [DW-1:0] tt_q, w_q, wt_q, v_q, ta_q, wb_q, vc_q;

  logic               pop, we;
  logic [AW+IW-1:0]   widx;
  logic [AW-1:0]      waddr, rd_addr;
  logic [RW-1:0]      rdata;
  logic [HW-1:0]      rd_hd;
  logic signed [VW-1:0] rd_val;
  logic [NW-1:0]      half, mid, i_clamp, rd_addr_n;
  logic [NW-1:0]      fa [4];
  logic signed [VW:0] dy;
  logic               div_go, mul_go, div_done, mul_done;
  logic signed [DW-1:0]  div_a, mul_a, mul_b, div_q, mul_p;
  logic signed [DVW-1:0] div_b;
  logic signed [MW:0]    sum1, sum2;
  logic signed [SW-1:0]  ysum;

  always_comb begin
    item_ready_o = (state_q == S_IDLE);
    pop   = item_valid_i && item_ready_o;
    we    = pop && (item_i.req_type == REQ_WRITE);
    widx  = (AW + IW)'(item_i.index);
    waddr = widx[AW-1:0];
    rd_hd  = rdata[RW-1:VW];
    rd_val = rdata[VW-1:0];
    half  = len_q >> 1;
    mid   = first_q + half;
    if (first_q == '0) begin
      i_clamp = NW'(1);
    end else if (first_q > n_q - 1'b1) begin
      i_clamp = n_q - 1'b1;
    end else begin
      i_clamp = first_q;
    end
    fa[0] = i_q - 1'b1;
    fa[1] = i_q;
    fa[2] = (i_q == NW'(1)) ? n_q - NW'(2) : i_q - NW'(2);
    fa[3] = (i_q == n_q - 1'b1) ? NW'(1) : i_q + 1'b1;
    rd_addr_n = (state_q == S_FETCH) ? fa[fcnt_q[1:0]] : mid;
    rd_addr   = rd_addr_n[AW-1:0];

    div_go = (state_q == S_M0 || state_q == S_M1 || state_q == S_M2 ||
              state_q == S_W || state_q == S_V) && !run_q;
    mul_go = (state_q == S_TT || state_q == S_WT || state_q == S_TS1 ||
              state_q == S_WP || state_q == S_VQ) && !run_q;

    unique case (state_q)
      S_M0:    dy = (VW + 1)'(y1_q) - (VW + 1)'(y0_q);
      S_M1:    dy = (VW + 1)'(y2_q) - (VW + 1)'(y1_q);
      default: dy = (VW + 1)'(y3_q) - (VW + 1)'(y2_q);
    endcase
    unique case (state_q)
      S_M0: begin
        div_a = DW'(dy) <<< FRAC;
        div_b = DVW'(x1_q) - DVW'(x0_q);
      end
      S_M1: begin
        div_a = DW'(dy) <<< FRAC;
        div_b = DVW'(x2_q) - DVW'(x1_q);
      end
      S_M2: begin
        div_a = DW'(dy) <<< FRAC;
        div_b = DVW'(x3_q) - DVW'(x2_q);
      end
      S_W: begin
        div_a = tt_q;
        div_b = h_q;
      end
      default: begin
        div_a = wt_q;
        div_b = h_q;
      end
    endcase
    unique case (state_q)
      S_TT: begin
        mul_a = DW'(t_q);
        mul_b = DW'(t_q);
      end
      S_WT: begin
        mul_a = w_q;
        mul_b = DW'(t_q);
      end
      S_TS1: begin
        mul_a = DW'(t_q);
        mul_b = DW'(s1_q);
      end
      S_WP: begin
        mul_a = w_q;
        mul_b = DW'(p_q);
      end
      default: begin
        mul_a = v_q;
        mul_b = DW'(q_q);
      end
    endcase

    sum1 = (MW + 1)'(m0_q) + (MW + 1)'(m1_q);
    sum2 = (MW + 1)'(m1_q) + (MW + 1)'(m2_q);
    ysum = SW'(y1_q) + SW'(ta_q >>> FRAC) + SW'(wb_q >>> FRAC) + SW'(vc_q >>> FRAC);
  end

  pcti_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({item_i.heading, item_i.value}),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  pcti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .a_i    (div_a),
    .b_i    (div_b),
    .done_o (div_done),
    .q_o    (div_q)
  );

  pcti_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      run_q          <= 1'b0;
      fcnt_q         <= '0;
      done_o         <= 1'b0;
      result_value_o <= '0;
      saturated_o    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (div_go || mul_go) begin
        run_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop && item_i.req_type == REQ_QUERY) begin
            x_q     <= item_i.heading;
            n_q     <= used_size_i;
            first_q <= '0;
            len_q   <= used_size_i;
            state_q <= S_SRD;
          end
        end
        S_SRD: begin
          if (len_q == '0) begin
            i_q     <= i_clamp;
            fcnt_q  <= '0;
            state_q <= S_FETCH;
          end else begin
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (x_q < rd_hd) begin
            len_q <= half;
          end else begin
            first_q <= mid + 1'b1;
            len_q   <= len_q - half - 1'b1;
          end
          state_q <= S_SRD;
        end
        S_FETCH: begin
          fcnt_q <= fcnt_q + 1'b1;
          unique case (fcnt_q)
            3'd1: begin
              x1_q <= $signed({2'b00, rd_hd});
              y1_q <= rd_val;
            end
            3'd2: begin
              x2_q <= $signed({2'b00, rd_hd});
              y2_q <= rd_val;
            end
            3'd3: begin
              x0_q <= (i_q == NW'(1)) ? $signed({2'b00, rd_hd}) - DEG360
                                      : $signed({2'b00, rd_hd});
              y0_q <= rd_val;
            end
            3'd4: begin
              x3_q <= (i_q == n_q - 1'b1) ? $signed({2'b00, rd_hd}) + DEG360
                                           : $signed({2'b00, rd_hd});
              y3_q    <= rd_val;
              state_q <= S_M0;
            end
            default: begin
            end
          endcase
        end
        S_M0, S_M1, S_M2, S_W, S_V: begin
          if (run_q && div_done) begin
            run_q <= 1'b0;
            unique case (state_q)
              S_M0: begin
                m0_q    <= div_q[MW-1:0];
                state_q <= S_M1;
              end
              S_M1: begin
                m1_q    <= div_q[MW-1:0];
                state_q <= S_M2;
              end
              S_M2: begin
                m2_q    <= div_q[MW-1:0];
                state_q <= S_SLOPE;
              end
              S_W: begin
                w_q     <= div_q;
                state_q <= S_WT;
              end
              default: begin
                v_q     <= div_q;
                state_q <= S_TS1;
              end
            endcase
          end
        end
        S_SLOPE: begin
          s1_q <= MW'((sum1 + $signed({{MW{1'b0}}, sum1[MW]})) >>> 1);
          s2_q <= MW'((sum2 + $signed({{MW{1'b0}}, sum2[MW]})) >>> 1);
          t_q  <= $signed({3'b000, x_q}) - DVW'(x1_q);
          h_q  <= DVW'(x2_q) - DVW'(x1_q);
          state_q <= S_PQ;
        end
        S_PQ: begin
          p_q <= (PW'(m1_q) <<< 1) + PW'(m1_q) - (PW'(s1_q) <<< 1) - PW'(s2_q);
          q_q <= PW'(s1_q) + PW'(s2_q) - (PW'(m1_q) <<< 1);
          state_q <= S_TT;
        end
        S_TT, S_WT, S_TS1, S_WP, S_VQ: begin
          if (run_q && mul_done) begin
            run_q <= 1'b0;
            unique case (state_q)
              S_TT: begin
                tt_q    <= mul_p;
                state_q <= S_W;
              end
              S_WT: begin
                wt_q    <= mul_p;
                state_q <= S_V;
              end
              S_TS1: begin
                ta_q    <= mul_p;
                state_q <= S_WP;
              end
              S_WP: begin
                wb_q    <= mul_p;
                state_q <= S_VQ;
              end
              default: begin
                vc_q    <= mul_p;
                state_q <= S_SUM;
              end
            endcase
          end
        end
        S_SUM: begin
          done_o <= 1'b1;
          if (ysum > YMAX) begin
            result_value_o <= YMAX[VW-1:0];
            saturated_o    <= 1'b1;
          end else if (ysum < YMIN) begin
            result_value_o <= YMIN[VW-1:0];
            saturated_o    <= 1'b1;
          end else begin
            result_value_o <= ysum[VW-1:0];
            saturated_o    <= 1'b0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PCTI_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held longer than one cycle")
  `PCTI_ASSERT_IMP(a_sat_extreme, done_o && saturated_o, result_value_o == YMAX[VW-1:0] || result_value_o == YMIN[VW-1:0], "saturated result not at a limit")
  `PCTI_ASSERT_IMP(a_fetch_range, state_q == S_FETCH && fcnt_q < 3'd4, NW'(rd_addr) < n_q, "neighbor fetch outside used table")
  `PCTI_ASSERT_IMP(a_idle_no_unit, state_q == S_IDLE, !run_q, "arithmetic unit running while idle")

endmodule

FILE: design/periodic_cubic_table_interpolator_unit.sv
// Periodic cubic table interpolator: top level with the table_size register.
// Depends on pcti_pkg, pcti_front and pcti_back.
//
// Usage: an item is taken on a rising edge with start high and busy low.
// req_type_i 0 writes entry_index_i with entry_heading_i / entry_value_i;
// indices at or beyond ENTRIES are dropped. req_type_i 1 queries
// query_heading_i and yields one result: done_o is high for exactly one
// cycle with result_value_o and saturated_o. Writes give no result.
// Items pass a two-deep queue; the back end runs one item at a time, so
// busy only rises while that queue is full.
// Flow: a write is stored once the idle back end takes it. A query runs the
// upper-bound search (up to 7 steps), the neighbor fetch, five divisions on
// the shared radix-4 divider and five multiplies on the shared 8-bit-digit
// multiplier. table_size is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while idle, since the block does not enforce it. Reset
// empties the queue, returns to idle and sets table_size to 3; table
// contents stay undefined until written. The receiver cannot stall results.
module periodic_cubic_table_interpolator_unit #(
  parameter int ENTRIES = pcti_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type_i,
  input  logic [pcti_pkg::IW-1:0]        entry_index_i,
  input  logic [pcti_pkg::HW-1:0]        entry_heading_i,
  input  logic signed [pcti_pkg::VW-1:0] entry_value_i,
  input  logic [pcti_pkg::HW-1:0]        query_heading_i,
  input  logic                           cfg_we_i,
  input  logic [pcti_pkg::TSW-1:0]       cfg_wdata_i,
  output logic                           done_o,
  output logic signed [pcti_pkg::VW-1:0] result_value_o,
  output logic                           saturated_o
);
  import pcti_pkg::*;

  localparam int NW = $clog2(ENTRIES + 1);
  localparam int CW = (NW > TSW) ? NW : TSW;

  logic [TSW-1:0] table_size_q;
  logic [CW-1:0]  ts_w, n_w;
  logic [NW-1:0]  used_size;
  logic           item_valid, item_ready;
  pcti_item_t     item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TS_RESET;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    ts_w = CW'(table_size_q);
    if (ts_w < CW'(TS_MIN)) begin
      n_w = CW'(TS_MIN);
    end else if (ts_w > CW'(ENTRIES)) begin
      n_w = CW'(ENTRIES);
    end else begin
      n_w = ts_w;
    end
    used_size = n_w[NW-1:0];
  end

  pcti_front #(.ENTRIES(ENTRIES)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .entry_heading_i (entry_heading_i),
    .entry_value_i   (entry_value_i),
    .query_heading_i (query_heading_i),
    .item_valid_o    (item_valid),
    .item_ready_i    (item_ready),
    .item_o          (item)
  );

  pcti_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .used_size_i    (used_size),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: dv/testbench.sv
// Testbench for periodic_cubic_table_interpolator_unit: fills the heading/value
// table, sweeps table_size settings and checks each query against a predictor.
// Depends on pcti_pkg and the RTL of the interpolator unit.
module testbench;
  import pcti_pkg::*;

  localparam longint MAXMAG = 64'sh3FFFFFFFFFFFFFFF;
  localparam longint FULL = 23592960;

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 sat;
  } interp_result_t;

  class interp_scoreboard;
    logic [HW-1:0]        heading_tbl[ENTRIES_DEF];
    logic signed [VW-1:0] value_tbl[ENTRIES_DEF];
    logic [TSW-1:0]       size_reg;
    interp_result_t       pending_q[$];
    int                   errors;

    function new();
      size_reg = TS_RESET;
      errors = 0;
      foreach (heading_tbl[k]) begin
        heading_tbl[k] = '0;
        value_tbl[k] = '0;
      end
    endfunction

    function longint clip(longint a);
      if (a > MAXMAG) return MAXMAG;
      if (a < -MAXMAG) return -MAXMAG;
      return a;
    endfunction

    function longint sat_add(longint a, longint b);
      return clip(clip(a) + clip(b));
    endfunction

    function longint sat_mul(longint a, longint b);
      longint unsigned ua, ub, p;
      bit neg;
      a = clip(a);
      b = clip(b);
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      if (ua != 0 && ub > longint'(MAXMAG) / ua) p = MAXMAG;
      else p = ua * ub;
      if (p > MAXMAG) p = MAXMAG;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function longint div0(longint a, longint b);
      if (b == 0) return 0;
      return clip(a) / b;
    endfunction

    function longint hd(int k);
      return longint'({39'd0, heading_tbl[k]});
    endfunction

    function longint vl(int k);
      return longint'(value_tbl[k]);
    endfunction

    function interp_result_t predict_value(logic [HW-1:0] qh);
      interp_result_t r;
      int n, i, first, len, half, mid;
      longint x, x0, x1, x2, x3, y0, y1, y2, y3;
      longint m0, m1, m2, s1, s2, p, q, t, h, w, v, y;
      n = (size_reg < TS_MIN) ? TS_MIN : ((size_reg > ENTRIES_DEF) ? ENTRIES_DEF : size_reg);
      x = longint'({39'd0, qh});
      first = 0;
      len = n;
      while (len > 0) begin
        half = len >> 1;
        mid = first + half;
        if (x < hd(mid)) len = half;
        else begin
          first = mid + 1;
          len = len - half - 1;
        end
      end
      i = first;
      if (i < 1) i = 1;
      if (i > n - 1) i = n - 1;
      x1 = hd(i - 1);
      x2 = hd(i);
      y1 = vl(i - 1);
      y2 = vl(i);
      if (i == 1) begin
        x0 = hd(n - 2) - FULL;
        y0 = vl(n - 2);
      end else begin
        x0 = hd(i - 2);
        y0 = vl(i - 2);
      end
      if (i == n - 1) begin
        x3 = hd(1) + FULL;
        y3 = vl(1);
      end else begin
        x3 = hd(i + 1);
        y3 = vl(i + 1);
      end
      m0 = div0((y1 - y0) * 65536, x1 - x0);
      m1 = div0((y2 - y1) * 65536, x2 - x1);
      m2 = div0((y3 - y2) * 65536, x3 - x2);
      s1 = (m0 + m1) / 2;
      s2 = (m1 + m2) / 2;
      p = 3 * m1 - 2 * s1 - s2;
      q = s1 + s2 - 2 * m1;
      t = x - x1;
      h = x2 - x1;
      w = div0(t * t, h);
      v = div0(sat_mul(w, t), h);
      y = sat_add(sat_add(sat_add(y1, sat_mul(t, s1) >>> 16), sat_mul(w, p) >>> 16),
                  sat_mul(v, q) >>> 16);
      r.sat = 1'b0;
      if (y > 64'sd2147483647) begin
        y = 64'sd2147483647;
        r.sat = 1'b1;
      end
      if (y < -64'sd2147483648) begin
        y = -64'sd2147483648;
        r.sat = 1'b1;
      end
      r.value = y[VW-1:0];
      return r;
    endfunction

    function void note_item(logic rt, logic [IW-1:0] idx, logic [HW-1:0] eh,
                            logic signed [VW-1:0] ev, logic [HW-1:0] qh);
      if (rt == REQ_WRITE) begin
        heading_tbl[idx] = eh;
        value_tbl[idx] = ev;
      end else pending_q.push_back(predict_value(qh));
    endfunction

    function void check_result(logic signed [VW-1:0] val, logic sat);
      interp_result_t w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d sat=%0b", $time, val, sat);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (val !== w.value) begin
        $display("%0t: result_value exp=%0d act=%0d", $time, w.value, val);
        errors++;
      end
      if (sat !== w.sat) begin
        $display("%0t: saturated exp=%0b act=%0b", $time, w.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i, rst_ni, start, busy;
  logic                 req_type_i;
  logic [IW-1:0]        entry_index_i;
  logic [HW-1:0]        entry_heading_i;
  logic signed [VW-1:0] entry_value_i;
  logic [HW-1:0]        query_heading_i;
  logic                 cfg_we_i;
  logic [TSW-1:0]       cfg_wdata_i;
  logic                 done_o, saturated_o;
  logic signed [VW-1:0] result_value_o;

  interp_scoreboard sb = new();
  int items_sent;

  periodic_cubic_table_interpolator_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_type_i(req_type_i), .entry_index_i(entry_index_i),
    .entry_heading_i(entry_heading_i), .entry_value_i(entry_value_i),
    .query_heading_i(query_heading_i), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o), .result_value_o(result_value_o), .saturated_o(saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_value_o, saturated_o);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic rt, logic [IW-1:0] idx, logic [HW-1:0] eh,
                           logic signed [VW-1:0] ev, logic [HW-1:0] qh, int gap);
    start <= 1'b1;
    req_type_i <= rt;
    entry_index_i <= idx;
    entry_heading_i <= eh;
    entry_value_i <= ev;
    query_heading_i <= qh;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(rt, idx, eh, ev, qh);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_entry(int idx, longint eh, longint ev);
    send_item(REQ_WRITE, idx[IW-1:0], eh[HW-1:0], ev[VW-1:0], HW'($urandom), pick_gap());
  endtask

  task automatic query(longint qh);
    send_item(REQ_QUERY, IW'($urandom), HW'($urandom), VW'($urandom), qh[HW-1:0],
              pick_gap());
  endtask

  task automatic set_size(int sz);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= sz[TSW-1:0];
    @(posedge clk_i);
    sb.size_reg = sz[TSW-1:0];
    cfg_we_i <= 1'b0;
  endtask

  // Ascending table over 0..360 with a chosen value style; noisy tables break the order.
  task automatic fill_table(int n, int style, bit noisy);
    longint stp, eh, ev;
    stp = FULL / (n - 1);
    for (int k = 0; k < n; k++) begin
      if (noisy) eh = $urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 2 ** HW - 1))
                      : longint'($urandom_range(0, 4)) * (FULL / 4);
      else if (k == 0) eh = 0;
      else if (k == n - 1) eh = FULL;
      else eh = k * stp + $urandom_range(0, stp / 2);
      case (style)
        0: ev = longint'(signed'(VW'($urandom)));
        1: ev = longint'($urandom_range(0, 2000)) - 1000;
        2: ev = (k % 2) ? 64'sd2147483647 : -64'sd2147483648;
        default: ev = longint'($urandom_range(0, 200000)) * ((k % 3) - 1) * 1000;
      endcase
      write_entry(k, eh, ev);
    end
  endtask

  function automatic longint rand_heading();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, FULL);
    if (r < 90) return (r % 2) ? FULL : 0;
    return $urandom_range(FULL, 2 ** HW - 1);
  endfunction

  initial begin
    int n, sz, r;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_type_i <= REQ_WRITE;
    entry_index_i <= '0;
    entry_heading_i <= '0;
    entry_value_i <= '0;
    query_heading_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry defined before any query
    for (int k = 0; k < ENTRIES_DEF; k++)
      write_entry(k, (k * FULL) / (ENTRIES_DEF - 1), longint'(signed'(VW'($urandom))));

    // directed: three-entry table at reset size, edges and saturation
    write_entry(0, 0, -64'sd2147483648);
    write_entry(1, FULL / 2, 64'sd2147483647);
    write_entry(2, FULL, -64'sd2147483648);
    query(0);
    query(FULL / 2);
    query(FULL);
    query(2 ** HW - 1);
    query(FULL / 4);
    write_entry(1, 1, 64'sd2147483647);
    query(1);
    query(FULL - 1);
    write_entry(1, 0, 0);
    query(0);
    query(FULL / 3);
    set_size(0);
    query(FULL / 5);
    set_size(127);
    query(FULL / 7);
    query(0);
    query(FULL);
    set_size(64);
    fill_table(64, 2, 1'b0);
    query(FULL / 128);
    query(FULL);

    while (items_sent < 1100) begin
      r = $urandom_range(0, 99);
      if (r < 8) sz = $urandom_range(0, 2);
      else if (r < 14) sz = $urandom_range(65, 127);
      else if (r < 24) sz = 64;
      else sz = $urandom_range(3, 12);
      set_size(sz);
      n = (sz < TS_MIN) ? TS_MIN : ((sz > ENTRIES_DEF) ? ENTRIES_DEF : sz);
      fill_table(n, $urandom_range(0, 3), $urandom_range(0, 6) == 0);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 19) == 0)
          write_entry($urandom_range(0, ENTRIES_DEF - 1), $urandom_range(0, 2 ** HW - 1),
                      longint'(signed'(VW'($urandom))));
        else query(rand_heading());
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end
endmodule
